### hdl/assert_macros.svh
// Assertion macros for the checker file of the NFA acceptor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also checks through reset.
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/nsa_pkg.sv
// Types and constants shared by the NFA acceptor files.
package nsa_pkg;

  localparam int STATE_IDX_W = 4;
  localparam int SYMBOL_W    = 4;
  localparam int MASK_W      = 16;
  localparam int START_W     = 4;
  localparam int ALPHA_W     = 5;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    ACT_WRITE_TRANS = 2'd0,
    ACT_WRITE_EPS   = 2'd1,
    ACT_CONSUME     = 2'd2,
    ACT_QUERY       = 2'd3
  } action_t;

  localparam logic [CFG_ADDR_W-1:0] CFG_START_STATE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACCEPT_MASK   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALPHABET_SIZE = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_USE_EPSILON   = 2'd3;

  localparam logic [START_W-1:0] START_STATE_RESET   = 4'd0;
  localparam logic [MASK_W-1:0]  ACCEPT_MASK_RESET   = 16'd0;
  localparam logic [ALPHA_W-1:0] ALPHABET_SIZE_RESET = 5'd16;
  localparam logic               USE_EPSILON_RESET   = 1'b1;

endpackage

### hdl/nsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module nsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/nsa_union.sv
// Shared set-union unit: ORs together the rows of every state in the select set.
module nsa_union #(
  parameter int NUM_STATES = 16
) (
  input  logic [NUM_STATES-1:0]                 sel,
  input  logic [NUM_STATES-1:0][NUM_STATES-1:0] rows,
  output logic [NUM_STATES-1:0]                 union_set
);

  always_comb begin
    union_set = '0;
    for (int s = 0; s < NUM_STATES; s++) begin
      if (sel[s]) begin
        union_set = union_set | rows[s];
      end
    end
  end

endmodule

### hdl/nfa_string_acceptor.sv
// NFA string acceptor. A consume item runs ST_SYM to ST_END, plus ST_DONE after a string's last
// symbol; a string's first symbol first closes the start set in ST_CLOSE_START. Epsilon closure
// takes one pass per cycle through the shared union unit until the set stops growing. A query
// closes the start set and reports; epsilon row writes end in ST_IDLE, transition row writes
// use ST_WRITE (read-modify-write of one RAM word per symbol). After reset the transition
// RAM is cleared one word a cycle with in_ready low; configuration registers reset at once.
module nfa_string_acceptor #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_SYMBOLS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  nsa_pkg::action_t                 in_action,
  input  logic [nsa_pkg::STATE_IDX_W-1:0]  in_state_index,
  input  logic [nsa_pkg::SYMBOL_W-1:0]     in_symbol,
  input  logic [nsa_pkg::MASK_W-1:0]       in_next_mask,
  input  logic                             in_last_symbol,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_accepted,
  output logic                             out_bad_symbol,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nsa_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [nsa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import nsa_pkg::*;

  localparam int NS = NUM_STATES;
  localparam int AW = $clog2(NUM_SYMBOLS);
  localparam int RW = NS * NS;

  typedef enum logic [8:0] {
    ST_CLEAR       = 9'b0_0000_0001,
    ST_IDLE        = 9'b0_0000_0010,
    ST_WRITE       = 9'b0_0000_0100,
    ST_CLOSE_START = 9'b0_0000_1000,
    ST_SYM         = 9'b0_0001_0000,
    ST_UNION       = 9'b0_0010_0000,
    ST_CLOSE_STEP  = 9'b0_0100_0000,
    ST_END         = 9'b0_1000_0000,
    ST_DONE        = 9'b1_0000_0000
  } seq_state_t;

  typedef logic [NS-1:0][NS-1:0] row_block_t;

  seq_state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // Item fields held while the item is worked on.
  action_t                act_r;
  logic [STATE_IDX_W-1:0] idx_r;
  logic [SYMBOL_W-1:0]    sym_r;
  logic [NS-1:0]          mask_r;
  logic                   last_r;

  logic [NS-1:0] work_r, work_nxt;
  logic [NS-1:0] active_r, active_nxt;
  logic          in_string_r, in_string_nxt;
  logic          saw_bad_r, saw_bad_nxt;
  logic          res_acc_r, res_acc_nxt;
  logic          res_bad_r, res_bad_nxt;

  logic          out_valid_r;
  logic          out_acc_r;
  logic          out_bad_r;

  logic [START_W-1:0] cfg_start_r;
  logic [MASK_W-1:0]  cfg_accept_r;
  logic [ALPHA_W-1:0] cfg_alpha_r;
  logic               cfg_use_eps_r;

  row_block_t eps_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_wdata;
  row_block_t    ram_rows;
  row_block_t    merged_rows;

  row_block_t    unit_rows;
  logic [NS-1:0] unit_sel;
  logic [NS-1:0] unit_out;
  logic [NS-1:0] grown;

  logic [NS-1:0] start_set;
  logic [NS-1:0] acc_set;
  logic          sym_bad;
  logic          trans_write_ok;
  logic          eps_write_ok;
  logic          in_fire;
  logic          out_load;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_acc_r;
  assign out_bad_symbol = out_bad_r;

  assign start_set = (32'(cfg_start_r) < NS) ? (NS'(1) << cfg_start_r) : '0;
  assign acc_set   = NS'(cfg_accept_r);
  assign sym_bad   = ({1'b0, sym_r} >= cfg_alpha_r) || (32'(sym_r) >= NUM_SYMBOLS);

  assign trans_write_ok = (32'(in_state_index) < NS) && (32'(in_symbol) < NUM_SYMBOLS);
  assign eps_write_ok   = (32'(in_state_index) < NS);

  // The read port follows the incoming symbol while idle so that the word is ready in the cycle
  // after the item is taken; afterwards it stays on the held symbol.
  assign ram_raddr = (state_r == ST_IDLE) ? AW'(in_symbol) : AW'(sym_r);

  nsa_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_SYMBOLS)
  ) u_trans_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rows)
  );

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      merged_rows[s] = (32'(idx_r) == s) ? mask_r : ram_rows[s];
    end
  end

  // One union unit serves both the transition step and every closure pass.
  assign unit_sel  = (state_r == ST_UNION) ? active_r : work_r;
  assign unit_rows = (state_r == ST_UNION) ? ram_rows : eps_r;

  nsa_union #(
    .NUM_STATES (NS)
  ) u_union (
    .sel       (unit_sel),
    .rows      (unit_rows),
    .union_set (unit_out)
  );

  assign grown = work_r | unit_out;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    work_nxt      = work_r;
    active_nxt    = active_r;
    in_string_nxt = in_string_r;
    saw_bad_nxt   = saw_bad_r;
    res_acc_nxt   = res_acc_r;
    res_bad_nxt   = res_bad_r;
    ram_we        = 1'b0;
    ram_waddr     = AW'(sym_r);
    ram_wdata     = merged_rows;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
        if (clr_cnt_r == AW'(NUM_SYMBOLS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            ACT_WRITE_TRANS: begin
              if (trans_write_ok) begin
                state_nxt = ST_WRITE;
              end
            end
            ACT_WRITE_EPS: begin
              state_nxt = ST_IDLE;
            end
            ACT_QUERY: begin
              work_nxt  = start_set;
              state_nxt = ST_CLOSE_START;
            end
            ACT_CONSUME: begin
              if (in_string_r) begin
                state_nxt = ST_SYM;
              end else begin
                work_nxt  = start_set;
                state_nxt = ST_CLOSE_START;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CLOSE_START: begin
        if (!cfg_use_eps_r || grown == work_r) begin
          if (act_r == ACT_QUERY) begin
            res_acc_nxt = |(work_r & acc_set);
            res_bad_nxt = 1'b0;
            state_nxt   = ST_DONE;
          end else begin
            active_nxt    = work_r;
            saw_bad_nxt   = 1'b0;
            in_string_nxt = 1'b1;
            state_nxt     = ST_SYM;
          end
        end else begin
          work_nxt = grown;
        end
      end
      ST_SYM: begin
        if (sym_bad) begin
          saw_bad_nxt = 1'b1;
          state_nxt   = ST_END;
        end else if (saw_bad_r) begin
          state_nxt = ST_END;
        end else begin
          state_nxt = ST_UNION;
        end
      end
      ST_UNION: begin
        work_nxt  = unit_out;
        state_nxt = ST_CLOSE_STEP;
      end
      ST_CLOSE_STEP: begin
        if (!cfg_use_eps_r || grown == work_r) begin
          active_nxt = work_r;
          state_nxt  = ST_END;
        end else begin
          work_nxt = grown;
        end
      end
      ST_END: begin
        if (last_r) begin
          res_acc_nxt   = !saw_bad_r && (|(active_r & acc_set));
          res_bad_nxt   = saw_bad_r;
          in_string_nxt = 1'b0;
          state_nxt     = ST_DONE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      active_r    <= '0;
      in_string_r <= 1'b0;
      saw_bad_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      active_r    <= active_nxt;
      in_string_r <= in_string_nxt;
      saw_bad_r   <= saw_bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r    <= work_nxt;
    res_acc_r <= res_acc_nxt;
    res_bad_r <= res_bad_nxt;
    if (in_fire) begin
      act_r  <= in_action;
      idx_r  <= in_state_index;
      sym_r  <= in_symbol;
      mask_r <= NS'(in_next_mask);
      last_r <= in_last_symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= '0;
    end else if (in_fire && in_action == ACT_WRITE_EPS && eps_write_ok) begin
      for (int s = 0; s < NS; s++) begin
        if (32'(in_state_index) == s) begin
          eps_r[s] <= NS'(in_next_mask);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_start_r   <= START_STATE_RESET;
      cfg_accept_r  <= ACCEPT_MASK_RESET;
      cfg_alpha_r   <= ALPHABET_SIZE_RESET;
      cfg_use_eps_r <= USE_EPSILON_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        CFG_START_STATE:   cfg_start_r   <= cfg_data[START_W-1:0];
        CFG_ACCEPT_MASK:   cfg_accept_r  <= cfg_data[MASK_W-1:0];
        CFG_ALPHABET_SIZE: cfg_alpha_r   <= cfg_data[ALPHA_W-1:0];
        CFG_USE_EPSILON:   cfg_use_eps_r <= cfg_data[0];
        default: cfg_use_eps_r <= cfg_use_eps_r;
      endcase
    end
  end

  // The result word sits in its own register so a new item can start while it waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_acc_r <= res_acc_r;
      out_bad_r <= res_bad_r;
    end
  end

endmodule

### hdl/nsa_checker.sv
// Port-level checker for the NFA acceptor, bound to the top level.
`include "assert_macros.svh"

module nsa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input nsa_pkg::action_t                 in_action,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_accepted,
  input logic                             out_bad_symbol
);

  import nsa_pkg::*;

  // A string with a bad symbol is never reported as accepted.
  `ASSERT_CLK(a_flags_exclusive, clk, rst_n, out_valid |-> !(out_accepted && out_bad_symbol), "accepted and bad_symbol both set")

  // After a query word is taken, in_ready stays low while the start set is closed.
  `ASSERT_CLK(a_query_busy, clk, rst_n, (in_valid && in_ready && in_action == ACT_QUERY) |=> !in_ready, "ready right after a query")

  // An epsilon row write completes in the cycle it is taken.
  `ASSERT_CLK(a_eps_write_quick, clk, rst_n, (in_valid && in_ready && in_action == ACT_WRITE_EPS) |=> in_ready, "epsilon write stalled the input")

  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_accepted) && $stable(out_bad_symbol)), "result word changed while stalled")

  `ASSERT_NORST(a_reset_out, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind nfa_string_acceptor nsa_checker u_nsa_checker (.*);
